// ----- hw/rtl/ced_pkg.sv -----
// Shared constants and types for the clamped-edge 2-D convolution core.
`default_nettype none
package ced_pkg;
    localparam int MAX_COLS   = 2048;
    localparam int MAX_KERNEL = 9;
    localparam int LINE_DEPTH = MAX_KERNEL * MAX_COLS;
    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int HALF_MAX   = (MAX_KERNEL - 1) / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int HALF_W     = 3;
    localparam int KW_W       = $clog2(MAX_KERNEL + 1);
    localparam int ROW_W      = 16;
    localparam int CFG_COL_W  = 12;
    localparam int POS_W      = ROW_W + COL_W + 1;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int ACC_W      = PROD_W + COEF_AW;

    typedef enum logic [1:0] {
        KIND_COEF  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_HALF = 2'd2,
        REG_NONE = 2'd3
    } t_reg;

    // one tap moving from the address sequencer into the MAC
    typedef struct packed {
        logic valid;
        logic last;
    } t_tap;
endpackage
`default_nettype wire

// ----- hw/rtl/ced_line_mem.sv -----
// Line storage: one write port, one registered read port.
`default_nettype none
module ced_line_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ced_pkg::LINE_AW-1:0] i_waddr,
    input  wire logic [ced_pkg::PIX_W-1:0]   i_wdata,
    input  wire logic [ced_pkg::LINE_AW-1:0] i_raddr,
    output logic      [ced_pkg::PIX_W-1:0]   o_rdata
);
    import ced_pkg::*;

    logic [PIX_W-1:0] r_mem [LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ced_coef_mem.sv -----
// Coefficient storage: one write port, one registered read port.
`default_nettype none
module ced_coef_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [ced_pkg::COEF_AW-1:0] i_waddr,
    input  wire logic signed [ced_pkg::COEF_W-1:0] i_wdata,
    input  wire logic [ced_pkg::COEF_AW-1:0] i_raddr,
    output logic signed [ced_pkg::COEF_W-1:0] o_rdata
);
    import ced_pkg::*;

    logic signed [COEF_W-1:0] r_mem [COEF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ced_mac.sv -----
// Multiply-accumulate over the window taps, then truncate and saturate.
`default_nettype none
module ced_mac (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire ced_pkg::t_tap                i_tap,
    input  wire logic [ced_pkg::PIX_W-1:0]    i_pix,
    input  wire logic signed [ced_pkg::COEF_W-1:0] i_coef,
    output logic                              o_done,
    output logic [ced_pkg::PIX_W-1:0]         o_pix,
    output logic                              o_clip
);
    import ced_pkg::*;

    logic                     r_prod_v, r_prod_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  sum;
    logic [PIX_W-1:0]         n_pix;
    logic                     n_clip;

    assign sum = r_acc + ACC_W'(r_prod);

    always_comb begin
        n_pix  = '0;
        n_clip = 1'b0;
        if (sum <= -ACC_W'(65536)) begin
            n_clip = 1'b1;
        end else if (sum < 0) begin
            n_pix = '0;
        end else if (sum[ACC_W-1:16] > (ACC_W-16)'(255)) begin
            n_pix  = '1;
            n_clip = 1'b1;
        end else begin
            n_pix = sum[16 +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            r_prod_v    <= i_tap.valid;
            r_prod_last <= i_tap.last;
            o_done      <= r_prod_v && r_prod_last;
        end
        r_prod <= $signed({1'b0, i_pix}) * i_coef;
        if (i_start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= sum;
        end
        if (r_prod_v && r_prod_last) begin
            o_pix  <= n_pix;
            o_clip <= n_clip;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/clamped_edge_2d_convolution_core.sv -----
// Top level: config registers, raster counters, window sequencer, output register.
// Coefficient loads, ignored items and pixels that cause no output leave the core in S_IDLE.
// An item that yields an output steps the row base back s = min(h, out_row) rows (w = 2h+1),
// then reads the w*w window taps, one per cycle, drains the MAC and emits; no new item is
// accepted until then, and a beat still waiting on i_m_axis_tready holds the next result in S_EMIT.
// Synchronous active-low reset restores register defaults, clears counters; memories keep data.
`default_nettype none
module clamped_edge_2d_convolution_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // coef_index[6:0], coef_value[24:7], pixel_in[32:25], zero pad
    input  wire logic [39:0] i_s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // pixel_out[7:0], clipped[8], zero pad
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ced_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROWUP, S_TAPS, S_DRAIN, S_EMIT} t_state;

    t_state                  r_state, n_state;
    logic [ROW_W-1:0]        r_rows;
    logic [CFG_COL_W-1:0]    r_cols;
    logic [HALF_W-1:0]       r_half;
    logic [ROW_W-1:0]        r_in_row, n_in_row, r_out_row, n_out_row, r_ir, n_ir;
    logic [COL_W-1:0]        r_in_col, n_in_col, r_out_col, n_out_col;
    logic [POS_W-1:0]        r_in_pos, n_in_pos;
    logic [LINE_AW-1:0]      r_wb, n_wb, r_ob, n_ob, r_rb, n_rb;
    logic [HALF_W-1:0]       r_step, n_step;
    logic signed [ROW_W+1:0] r_nrow, n_nrow, nrow_next;
    logic [KW_W-1:0]         r_fr, n_fr, r_fc, n_fc;
    logic [COEF_AW-1:0]      r_ci, n_ci;
    t_tap                    r_tap, tap;
    logic                    r_m_valid, n_m_valid, r_last, n_last;
    logic [PIX_W-1:0]        r_m_pix, n_m_pix;
    logic                    r_m_clip, n_m_clip;

    logic [ROW_W-1:0]        rows_e;
    logic [CFG_COL_W-1:0]    cols_e;
    logic [HALF_W-1:0]       half_e;
    logic [KW_W-1:0]         kw;
    logic [POS_W-1:0]        lag;
    logic                    accept, cfg_we, start, line_we, coef_we, emit_load, is_last;
    t_kind                   kind;
    logic [COEF_AW-1:0]      coef_idx;
    logic signed [COL_W+2:0] ncol;
    logic [COL_W-1:0]        ic;
    logic [LINE_AW:0]        raddr_sum;
    logic [LINE_AW-1:0]      raddr;
    logic [PIX_W-1:0]        rd_pix, mac_pix;
    logic signed [COEF_W-1:0] rd_coef;
    logic                    mac_done, mac_clip;

    assign rows_e = (r_rows == '0) ? ROW_W'(1) : r_rows;
    assign cols_e = (r_cols == '0) ? CFG_COL_W'(1) :
                    (r_cols > CFG_COL_W'(MAX_COLS)) ? CFG_COL_W'(MAX_COLS) : r_cols;
    assign half_e = (r_half > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : r_half;
    assign kw     = KW_W'({half_e, 1'b1});
    assign lag    = POS_W'(half_e * cols_e) + POS_W'(half_e);

    assign pready          = 1'b1;
    assign cfg_we          = psel && penable && pwrite;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign kind            = t_kind'(i_s_axis_tuser);
    assign coef_idx        = i_s_axis_tdata[COEF_AW-1:0];

    assign line_we = accept && (kind == KIND_PIXEL) && (r_in_row < rows_e);
    assign coef_we = accept && (kind == KIND_COEF) &&
                     ({1'b0, i_s_axis_tdata[6:0]} < 8'(COEF_DEPTH));
    assign start   = (line_we && (r_in_pos >= lag)) ||
                     (accept && (kind == KIND_FLUSH) && (r_in_row >= rows_e));

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_ROWS: prdata = 32'(r_rows);
            REG_COLS: prdata = 32'(r_cols);
            REG_HALF: prdata = 32'(r_half);
            default:  prdata = '0;
        endcase
    end

    // clamp the window column into the frame and form the ring address
    assign ncol = $signed({3'b0, r_out_col}) - $signed((COL_W+3)'(half_e))
                + $signed((COL_W+3)'(r_fc));
    always_comb begin
        if (ncol < 0) begin
            ic = '0;
        end else if (ncol > $signed((COL_W+3)'(cols_e) - (COL_W+3)'(1))) begin
            ic = COL_W'(cols_e - CFG_COL_W'(1));
        end else begin
            ic = ncol[COL_W-1:0];
        end
        raddr_sum = (LINE_AW+1)'(r_rb) + (LINE_AW+1)'(ic);
        raddr     = (raddr_sum >= (LINE_AW+1)'(LINE_DEPTH)) ?
                    LINE_AW'(raddr_sum - (LINE_AW+1)'(LINE_DEPTH)) : raddr_sum[LINE_AW-1:0];
    end

    assign tap.valid = (r_state == S_TAPS);
    assign tap.last  = (r_fr == kw - KW_W'(1)) && (r_fc == kw - KW_W'(1));
    assign nrow_next = r_nrow + (ROW_W+2)'(1);
    assign emit_load = (r_state == S_EMIT) && (!r_m_valid || i_m_axis_tready);
    assign is_last   = (r_out_row == rows_e - ROW_W'(1)) &&
                       ({1'b0, r_out_col} == cols_e - CFG_COL_W'(1));

    always_comb begin
        n_state   = r_state;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_in_pos  = r_in_pos;
        n_wb      = r_wb;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_ob      = r_ob;
        n_rb      = r_rb;
        n_ir      = r_ir;
        n_step    = r_step;
        n_nrow    = r_nrow;
        n_fr      = r_fr;
        n_fc      = r_fc;
        n_ci      = r_ci;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_pix   = r_m_pix;
        n_m_clip  = r_m_clip;
        n_last    = r_last;

        if (line_we) begin
            n_in_pos = r_in_pos + POS_W'(1);
            n_wb     = (r_wb == LINE_AW'(LINE_DEPTH - 1)) ? '0 : r_wb + LINE_AW'(1);
            if ((CFG_COL_W'(r_in_col) + CFG_COL_W'(1)) >= cols_e) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ROWUP;
                    n_rb    = r_ob;
                    n_ir    = r_out_row;
                    n_step  = '0;
                end
            end
            S_ROWUP: begin
                // step the row base back to the top window row
                if (r_step < half_e && r_ir != '0) begin
                    n_step = r_step + HALF_W'(1);
                    n_ir   = r_ir - ROW_W'(1);
                    n_rb   = (r_rb >= LINE_AW'(cols_e)) ? r_rb - LINE_AW'(cols_e) :
                             LINE_AW'((LINE_AW+1)'(r_rb) + (LINE_AW+1)'(LINE_DEPTH)
                                      - (LINE_AW+1)'(cols_e));
                end else begin
                    n_state = S_TAPS;
                    n_nrow  = $signed({2'b0, r_out_row}) - $signed((ROW_W+2)'(half_e));
                    n_fr    = '0;
                    n_fc    = '0;
                    n_ci    = '0;
                end
            end
            S_TAPS: begin
                n_ci = r_ci + COEF_AW'(1);
                if (tap.last) begin
                    n_state = S_DRAIN;
                end else if (r_fc == kw - KW_W'(1)) begin
                    n_fc   = '0;
                    n_fr   = r_fr + KW_W'(1);
                    n_nrow = nrow_next;
                    if (nrow_next > $signed({2'b0, r_ir}) && r_ir < rows_e - ROW_W'(1)) begin
                        n_ir = r_ir + ROW_W'(1);
                        n_rb = ((LINE_AW+1)'(r_rb) + (LINE_AW+1)'(cols_e) >=
                                (LINE_AW+1)'(LINE_DEPTH)) ?
                               LINE_AW'((LINE_AW+1)'(r_rb) + (LINE_AW+1)'(cols_e)
                                        - (LINE_AW+1)'(LINE_DEPTH)) :
                               r_rb + LINE_AW'(cols_e);
                    end
                end else begin
                    n_fc = r_fc + KW_W'(1);
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    n_m_pix   = mac_pix;
                    n_m_clip  = mac_clip;
                    n_last    = is_last;
                    if (is_last) begin
                        n_in_row  = '0;
                        n_in_col  = '0;
                        n_in_pos  = '0;
                        n_wb      = '0;
                        n_out_row = '0;
                        n_out_col = '0;
                        n_ob      = '0;
                    end else if ((CFG_COL_W'(r_out_col) + CFG_COL_W'(1)) >= cols_e) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + ROW_W'(1);
                        n_ob = ((LINE_AW+1)'(r_ob) + (LINE_AW+1)'(cols_e) >=
                                (LINE_AW+1)'(LINE_DEPTH)) ?
                               LINE_AW'((LINE_AW+1)'(r_ob) + (LINE_AW+1)'(cols_e)
                                        - (LINE_AW+1)'(LINE_DEPTH)) :
                               r_ob + LINE_AW'(cols_e);
                    end else begin
                        n_out_col = r_out_col + COL_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a write to the rows, cols or half register restarts the frame
        if (cfg_we && t_reg'(paddr[3:2]) != REG_NONE) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_in_pos  = '0;
            n_wb      = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_ob      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows    <= ROW_W'(1);
            r_cols    <= CFG_COL_W'(1);
            r_half    <= HALF_W'(4);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_pos  <= '0;
            r_wb      <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_ob      <= '0;
            r_m_valid <= 1'b0;
            r_tap     <= '0;
        end else begin
            r_state   <= n_state;
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_in_pos  <= n_in_pos;
            r_wb      <= n_wb;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_ob      <= n_ob;
            r_m_valid <= n_m_valid;
            r_tap     <= tap;
            if (cfg_we) begin
                unique case (t_reg'(paddr[3:2]))
                    REG_ROWS: r_rows <= pwdata[ROW_W-1:0];
                    REG_COLS: r_cols <= pwdata[CFG_COL_W-1:0];
                    REG_HALF: r_half <= pwdata[HALF_W-1:0];
                    default:  ;
                endcase
            end
        end
        r_rb     <= n_rb;
        r_ir     <= n_ir;
        r_step   <= n_step;
        r_nrow   <= n_nrow;
        r_fr     <= n_fr;
        r_fc     <= n_fc;
        r_ci     <= n_ci;
        r_m_pix  <= n_m_pix;
        r_m_clip <= n_m_clip;
        r_last   <= n_last;
    end

    ced_line_mem u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_wb),
        .i_wdata (i_s_axis_tdata[32:25]),
        .i_raddr (raddr),
        .o_rdata (rd_pix)
    );

    ced_coef_mem u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_idx),
        .i_wdata ($signed(i_s_axis_tdata[24:7])),
        .i_raddr (r_ci),
        .o_rdata (rd_coef)
    );

    ced_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_tap   (r_tap),
        .i_pix   (rd_pix),
        .i_coef  (rd_coef),
        .o_done  (mac_done),
        .o_pix   (mac_pix),
        .o_clip  (mac_clip)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'b0, r_m_clip, r_m_pix};
    assign o_m_axis_tlast  = r_last;
endmodule
`default_nettype wire

// ----- tb/clamped_edge_2d_convolution_checker.sv -----
// Checker for the clamped-edge 2-D convolution core: window predictor and output compare.
`timescale 1ns / 100ps
module clamped_edge_2d_convolution_checker
    import ced_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_error_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] pix;
        logic       clip;
        logic       last;
    } t_filtered;

    t_filtered               expected_pixels[$];
    logic [7:0]              line_mem [LINE_DEPTH];
    logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
    logic [15:0]             rows_reg;
    logic [11:0]             cols_reg;
    logic [2:0]              half_reg;
    longint                  in_row, in_col, out_row, out_col;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        for (int i = 0; i < COEF_DEPTH; i++) coef_mem[i] = '0;
    end

    function automatic longint eff_rows();
        return (rows_reg == 0) ? 1 : longint'(rows_reg);
    endfunction

    function automatic longint eff_cols();
        if (cols_reg == 0) return 1;
        return (cols_reg > MAX_COLS) ? MAX_COLS : longint'(cols_reg);
    endfunction

    function automatic longint eff_half();
        return (half_reg > HALF_MAX) ? HALF_MAX : longint'(half_reg);
    endfunction

    // Filter the window around (out_row, out_col), then advance or restart the raster.
    function automatic t_filtered filter_next_pixel();
        longint    rows, cols, h, ir, ic, acc, t;
        int        ci;
        t_filtered res;
        rows = eff_rows();
        cols = eff_cols();
        h    = eff_half();
        acc  = 0;
        for (longint fr = -h; fr <= h; fr++) begin
            for (longint fc = -h; fc <= h; fc++) begin
                ir = out_row + fr;
                ic = out_col + fc;
                if (ir < 0) ir = 0;
                if (ir > rows - 1) ir = rows - 1;
                if (ic < 0) ic = 0;
                if (ic > cols - 1) ic = cols - 1;
                ci = int'((fr + h) * (2 * h + 1) + (fc + h));
                acc += longint'(line_mem[(ir * cols + ic) % LINE_DEPTH]) *
                       longint'(coef_mem[ci]);
            end
        end
        res.clip = 1'b0;
        if (acc <= -65536) begin
            res.pix  = 8'd0;
            res.clip = 1'b1;
        end else if (acc < 0) begin
            res.pix = 8'd0;
        end else begin
            t = acc >>> 16;
            if (t > 255) begin
                res.pix  = 8'd255;
                res.clip = 1'b1;
            end else begin
                res.pix = t[7:0];
            end
        end
        res.last = (out_row == rows - 1) && (out_col == cols - 1);
        if (res.last) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else if (out_col + 1 >= cols) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return res;
    endfunction

    function automatic void apply_beat(logic [1:0] kind, logic [39:0] data);
        longint rows, cols, lag, p;
        rows = eff_rows();
        cols = eff_cols();
        lag  = eff_half() * cols + eff_half();
        case (t_kind'(kind))
            KIND_COEF: begin
                if (data[6:0] < COEF_DEPTH) coef_mem[data[6:0]] = data[24:7];
            end
            KIND_PIXEL: begin
                if (in_row < rows) begin
                    p = in_row * cols + in_col;
                    line_mem[p % LINE_DEPTH] = data[32:25];
                    if (in_col + 1 >= cols) begin
                        in_col = 0;
                        in_row++;
                    end else begin
                        in_col++;
                    end
                    if (p >= lag) expected_pixels.push_back(filter_next_pixel());
                end
            end
            KIND_FLUSH: begin
                if (in_row >= rows) expected_pixels.push_back(filter_next_pixel());
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_filtered want;
        if (!i_rst_n) begin
            rows_reg = 16'd1;
            cols_reg = 12'd1;
            half_reg = 3'd4;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            expected_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_ROWS: rows_reg = i_pwdata[15:0];
                    REG_COLS: cols_reg = i_pwdata[11:0];
                    REG_HALF: half_reg = i_pwdata[2:0];
                    default: ;
                endcase
                if (t_reg'(i_paddr[3:2]) != REG_NONE) begin
                    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
                    expected_pixels.delete();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output beat pix=%0d clip=%b last=%b", $time,
                             i_m_tdata[7:0], i_m_tdata[8], i_m_tlast);
                    o_error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_m_tdata[7:0] !== want.pix) begin
                        $display("%0t: pixel_out expected %0d actual %0d", $time,
                                 want.pix, i_m_tdata[7:0]);
                        o_error_count++;
                    end
                    if (i_m_tdata[8] !== want.clip) begin
                        $display("%0t: clipped expected %b actual %b", $time,
                                 want.clip, i_m_tdata[8]);
                        o_error_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $display("%0t: frame_end expected %b actual %b", $time,
                                 want.last, i_m_tlast);
                        o_error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) apply_beat(i_s_tuser, i_s_tdata);
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ----- tb/clamped_edge_2d_convolution_core_test.sv -----
// Testbench top: clock, reset, stimulus and verdict for the convolution core.
`timescale 1ns / 100ps
module clamped_edge_2d_convolution_core_test;
    import ced_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 3000;
    localparam int DRAIN_WAIT  = 150;
    localparam int ITEM_TARGET = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;
    int          error_count;
    int          pending_count;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          hold_output = 0;
    bit          no_gaps = 0;

    clamped_edge_2d_convolution_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    clamped_edge_2d_convolution_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_error_count(error_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_output = 0;
            end else begin
                int n;
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(t_kind kind, logic [6:0] idx, logic [17:0] coef,
                             logic [7:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, pix, coef, idx};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_pixel(logic [7:0] pix);
        send_beat(KIND_PIXEL, 7'($urandom), 18'($urandom), pix);
    endtask

    task automatic send_flush();
        send_beat(KIND_FLUSH, 7'($urandom), 18'($urandom), 8'($urandom));
    endtask

    task automatic send_coef(logic [6:0] idx, logic [17:0] coef);
        send_beat(KIND_COEF, idx, coef, 8'($urandom));
    endtask

    // Let every pending output drain and the window engine go quiet.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] rows, logic [31:0] cols, logic [31:0] half);
        drain_outputs();
        write_register(REG_HALF, half);
        write_register(REG_COLS, cols);
        write_register(REG_ROWS, rows);
    endtask

    function automatic logic [17:0] random_coef();
        if ($urandom_range(0, 4) == 0) return 18'($urandom);
        return 18'($urandom_range(0, 60000) - 20000);
    endfunction

    // One frame of pixels with optional noise, then the flushes that drain it.
    task automatic run_frame(int rows, int cols, int half, bit noisy);
        int r, c, h, lag, total, flushes;
        r = (rows == 0) ? 1 : rows;
        c = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
        h = (half > HALF_MAX) ? HALF_MAX : half;
        lag = h * c + h;
        total = r * c;
        flushes = (lag < total) ? lag : total;
        for (int p = 0; p < total; p++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_beat(KIND_NONE, 7'($urandom), 18'($urandom), 8'($urandom));
                    1: send_flush();
                    default: send_coef(7'($urandom), random_coef());
                endcase
            end
            case ($urandom_range(0, 9))
                0: send_pixel(8'd0);
                1: send_pixel(8'd255);
                default: send_pixel(8'($urandom));
            endcase
        end
        if (noisy && $urandom_range(0, 3) == 0) send_pixel(8'($urandom));
        repeat (flushes) send_flush();
        if (noisy && $urandom_range(0, 3) == 0) send_flush();
    endtask

    initial begin
        int rows, cols, half, frame_no;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full coefficient set, ignored indexes, small frames, extremes.
        write_register(REG_NONE, 32'hFFFF_FFFF);
        for (int i = 0; i < COEF_DEPTH; i++) send_coef(7'(i), 18'($urandom_range(0, 6000)));
        send_coef(7'd81, 18'h1FFFF);
        send_coef(7'd127, 18'h20000);
        configure(32'hFFFF_0003, 32'hFFFF_F004, 32'hFFFF_FFF9);
        send_flush();
        send_beat(KIND_NONE, 7'h7F, 18'h3FFFF, 8'hFF);
        run_frame(3, 4, 7, 1'b0);
        send_pixel(8'hAA);
        send_flush();
        configure(2, 3, 0);
        send_coef(7'd0, 18'h1FFFF);
        run_frame(2, 3, 0, 1'b0);
        send_coef(7'd0, 18'h20000);
        run_frame(2, 3, 0, 1'b0);
        send_coef(7'd0, 18'h10000);
        configure(0, 0, 7);
        run_frame(0, 0, 7, 1'b1);

        // Unfinished large frame: widest row, most rows; restarted by the next write.
        configure(65535, 4095, 4);
        repeat (40) send_pixel(8'($urandom));

        frame_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
                rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(1, 6);
                cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(1, 10);
                half = $urandom_range(0, 7);
                configure(rows, cols, half);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if (frame_no == 3) hold_output = 1;
            repeat ($urandom_range(0, 3)) send_coef(7'($urandom_range(0, COEF_DEPTH - 1)),
                                                   random_coef());
            run_frame(rows, cols, half, $urandom_range(0, 3) != 0);
            frame_no++;
        end

        no_gaps = 0;
        drain_outputs();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ced_pkg.sv
hw/rtl/ced_line_mem.sv
hw/rtl/ced_coef_mem.sv
hw/rtl/ced_mac.sv
hw/rtl/clamped_edge_2d_convolution_core.sv
tb/clamped_edge_2d_convolution_checker.sv
tb/clamped_edge_2d_convolution_core_test.sv
